FILE: rtl/ccds_pkg.sv
// Shared types, constants and helper functions for the multiplexed clock core.
// No dependencies; used by clock_counter_with_display_scan_core.
`default_nettype none

package ccds_pkg;

  // Number of scanned display digits: seconds, minutes and hours, two digits each.
  localparam int unsigned DIGIT_COUNT = 6;
  localparam int unsigned SCAN_W      = $clog2(DIGIT_COUNT + 1);

  localparam logic [5:0] SEC_MAX  = 6'd59;
  localparam logic [5:0] MIN_MAX  = 6'd59;
  localparam logic [4:0] HOUR_MAX = 5'd23;
  localparam logic [4:0] NOON     = 5'd12;
  localparam logic [2:0] ANODE_OFF = 3'd7;

  typedef enum logic [2:0] {
    ACT_TICK     = 3'd0,
    ACT_SET_SEC  = 3'd1,
    ACT_SET_MIN  = 3'd2,
    ACT_SET_HOUR = 3'd3,
    ACT_SCAN     = 3'd4,
    ACT_BLANK    = 3'd5
  } action_e;

  typedef struct packed {
    logic [2:0] tens;
    logic [3:0] units;
  } bcd_t;

  // Split a value below 64 into decimal tens and units by threshold compares.
  function automatic bcd_t bcd_split(logic [5:0] v);
    bcd_t r;
    r.tens = 3'd0;
    if      (v >= 6'd60) r.tens = 3'd6;
    else if (v >= 6'd50) r.tens = 3'd5;
    else if (v >= 6'd40) r.tens = 3'd4;
    else if (v >= 6'd30) r.tens = 3'd3;
    else if (v >= 6'd20) r.tens = 3'd2;
    else if (v >= 6'd10) r.tens = 3'd1;
    r.units = 4'(v - 6'(r.tens) * 6'd10);
    return r;
  endfunction

  // Hours as shown: 12-hour form maps 0 to 12 and 13..23 to 1..11.
  function automatic logic [4:0] shown_hours(logic [4:0] h, logic twelve);
    logic [4:0] r;
    r = h;
    if (twelve) begin
      if (h == 5'd0)      r = NOON;
      else if (h > NOON)  r = h - NOON;
    end
    return r;
  endfunction

  // Anode decoder code is the digit index with its three bits reversed.
  function automatic logic [2:0] anode_code(logic [2:0] idx);
    return {idx[0], idx[1], idx[2]};
  endfunction

  // BCD numeral of one display digit, units first, hours tens last.
  function automatic logic [3:0] digit_at(logic [SCAN_W-1:0] idx, logic [5:0] sec,
                                          logic [5:0] mins, logic [4:0] hrs);
    bcd_t s;
    bcd_t m;
    bcd_t h;
    logic [3:0] d;
    s = bcd_split(sec);
    m = bcd_split(mins);
    h = bcd_split({1'b0, hrs});
    unique case (idx)
      SCAN_W'(0): d = s.units;
      SCAN_W'(1): d = {1'b0, s.tens};
      SCAN_W'(2): d = m.units;
      SCAN_W'(3): d = {1'b0, m.tens};
      SCAN_W'(4): d = h.units;
      SCAN_W'(5): d = {1'b0, h.tens};
      default:    d = 4'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/clock_counter_with_display_scan_core.sv
// Multiplexed HH:MM:SS clock core with six-digit display scan.
// A result is held in the output register, or in the skid stage while stalled.
// Throughput: one item per cycle while the skid stage is empty; an output register
// plus a skid stage keep intake open for one more item while a result is stalled.
// Reset: time, scan index, colon, drives and 12-hour mode clear to zero.
// Depends on ccds_pkg for action codes and the BCD/hour helpers.
`default_nettype none

module clock_counter_with_display_scan_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // configuration: 12-hour display mode
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_data_i,
  // item intake
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [2:0] action_i,
  input  wire logic       seconds_held_i,
  // result delivery
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [2:0]      anode_select_o,
  output logic [3:0]      cathode_digit_o,
  output logic            decimal_point_o,
  output logic            colon_on_o,
  output logic [4:0]      shown_hours_o,
  output logic [5:0]      shown_minutes_o,
  output logic [5:0]      shown_seconds_o
);

  localparam int unsigned SW = ccds_pkg::SCAN_W;
  localparam logic [SW-1:0] DIGIT_CAP = SW'(ccds_pkg::DIGIT_COUNT);

  typedef struct packed {
    logic [2:0] anode;
    logic [3:0] cathode;
    logic       dot;
    logic       colon;
    logic [4:0] hours;
    logic [5:0] mins;
    logic [5:0] secs;
  } result_t;

  // Architectural state
  logic          twelve_q;
  logic [5:0]    sec_q, sec_d;
  logic [5:0]    min_q, min_d;
  logic [4:0]    hour_q, hour_d;
  logic [SW-1:0] scan_q, scan_d;
  logic          colon_q, colon_d;
  logic          phase_q, phase_d;
  logic [2:0]    anode_q, anode_d;
  logic [3:0]    cathode_q, cathode_d;
  logic          dot_q, dot_d;

  // Result path: output register and skid stage
  logic    out_valid_q;
  logic    skid_valid_q;
  result_t out_q;
  result_t skid_q;
  result_t res_d;

  logic          in_acc;
  logic          out_take;
  logic [SW-1:0] scan_idx;
  logic [4:0]    hrs_shown;

  // Intake stays open until the skid stage is occupied.
  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i & ~skid_valid_q;
  assign out_take   = out_valid_q & ~out_stall_i;

  // A scan step at the cap restarts from the seconds units digit.
  assign scan_idx  = (scan_q >= DIGIT_CAP) ? '0 : scan_q;
  assign hrs_shown = ccds_pkg::shown_hours(hour_q, twelve_q);

  // Next state for one item
  always_comb begin
    sec_d     = sec_q;
    min_d     = min_q;
    hour_d    = hour_q;
    scan_d    = scan_q;
    colon_d   = colon_q;
    phase_d   = phase_q;
    anode_d   = anode_q;
    cathode_d = cathode_q;
    dot_d     = dot_q;
    unique case (ccds_pkg::action_e'(action_i))
      ccds_pkg::ACT_TICK: begin
        // colon follows the tick phase; held set-seconds freezes counting
        phase_d = ~phase_q;
        colon_d = ~phase_q;
        if (!seconds_held_i) begin
          if (sec_q >= ccds_pkg::SEC_MAX) begin
            sec_d = '0;
            if (min_q >= ccds_pkg::MIN_MAX) begin
              min_d  = '0;
              hour_d = (hour_q >= ccds_pkg::HOUR_MAX) ? '0 : hour_q + 5'd1;
            end else begin
              min_d = min_q + 6'd1;
            end
          end else begin
            sec_d = sec_q + 6'd1;
          end
        end
      end
      ccds_pkg::ACT_SET_SEC: begin
        colon_d = 1'b1;
        sec_d   = (sec_q >= ccds_pkg::SEC_MAX) ? '0 : sec_q + 6'd1;
      end
      ccds_pkg::ACT_SET_MIN: begin
        colon_d = 1'b1;
        min_d   = (min_q >= ccds_pkg::MIN_MAX) ? '0 : min_q + 6'd1;
      end
      ccds_pkg::ACT_SET_HOUR: begin
        colon_d = 1'b1;
        hour_d  = (hour_q >= ccds_pkg::HOUR_MAX) ? '0 : hour_q + 5'd1;
      end
      ccds_pkg::ACT_SCAN: begin
        // PM dot only on the hours tens digit
        scan_d    = scan_idx;
        dot_d     = twelve_q && (scan_idx == SW'(5)) && (hour_q > 5'd11);
        anode_d   = ccds_pkg::anode_code(3'(scan_idx));
        cathode_d = ccds_pkg::digit_at(scan_idx, sec_q, min_q, hrs_shown);
      end
      ccds_pkg::ACT_BLANK: begin
        // drop all anodes, advance the digit but stop at the cap
        cathode_d = ccds_pkg::digit_at(scan_q, sec_q, min_q, hrs_shown);
        anode_d   = ccds_pkg::ANODE_OFF;
        if (scan_q < DIGIT_CAP) scan_d = scan_q + SW'(1);
      end
      default: ;  // unused codes leave everything as is
    endcase
  end

  // Result reflects the state after the update
  always_comb begin
    res_d.anode   = anode_d;
    res_d.cathode = cathode_d;
    res_d.dot     = dot_d;
    res_d.colon   = colon_d;
    res_d.hours   = ccds_pkg::shown_hours(hour_d, twelve_q);
    res_d.mins    = min_d;
    res_d.secs    = sec_d;
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      twelve_q <= 1'b0;
    end else if (cfg_we_i) begin
      twelve_q <= cfg_data_i;
    end
  end

  // Time, scan and drive state advance once per accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_q     <= '0;
      min_q     <= '0;
      hour_q    <= '0;
      scan_q    <= '0;
      colon_q   <= 1'b0;
      phase_q   <= 1'b0;
      anode_q   <= '0;
      cathode_q <= '0;
      dot_q     <= 1'b0;
    end else if (in_acc) begin
      sec_q     <= sec_d;
      min_q     <= min_d;
      hour_q    <= hour_d;
      scan_q    <= scan_d;
      colon_q   <= colon_d;
      phase_q   <= phase_d;
      anode_q   <= anode_d;
      cathode_q <= cathode_d;
      dot_q     <= dot_d;
    end
  end

  // Output register and skid stage: the skid catches one item that arrives
  // while the output is stalled, and drains into the output first.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_take) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_take) begin
      if (skid_valid_q) out_q <= skid_q;
      else if (in_acc)  out_q <= res_d;
    end else if (in_acc) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign anode_select_o  = out_q.anode;
  assign cathode_digit_o = out_q.cathode;
  assign decimal_point_o = out_q.dot;
  assign colon_on_o      = out_q.colon;
  assign shown_hours_o   = out_q.hours;
  assign shown_minutes_o = out_q.mins;
  assign shown_seconds_o = out_q.secs;

  // Checks

  // A held item in the skid stage always has a result ahead of it.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage full with output register empty");

  // Full rollover of seconds and minutes on an unheld tick.
  a_tick_rollover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && action_i == ccds_pkg::ACT_TICK && !seconds_held_i &&
     sec_q == ccds_pkg::SEC_MAX && min_q == ccds_pkg::MIN_MAX)
    |=> (sec_q == 6'd0 && min_q == 6'd0))
    else $error("tick rollover did not clear seconds and minutes");

  // A blank step always leaves no anode selected and the index within the cap.
  a_blank_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && action_i == ccds_pkg::ACT_BLANK)
    |=> (anode_q == ccds_pkg::ANODE_OFF && scan_q <= DIGIT_CAP))
    else $error("blank step left an anode driven or index past cap");

  // Time fields stay in range.
  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_q <= ccds_pkg::SEC_MAX && min_q <= ccds_pkg::MIN_MAX &&
    hour_q <= ccds_pkg::HOUR_MAX)
    else $error("time counter out of range");

endmodule

`default_nettype wire
